// ----- rtl/tcst_pkg.sv -----
// tcst_pkg: state codes, item structs and config defaults for the
// tcp connection state tracker; used by every rtl file of the block
`default_nettype none

package tcst_pkg;

  localparam int unsigned PortW  = 16;
  localparam int unsigned StateW = 4;
  localparam int unsigned CfgIdxW = 2;

  // connection and proxy state codes, shared by all four state fields
  localparam logic [StateW-1:0] ST_LISTEN       = 4'd0;
  localparam logic [StateW-1:0] ST_SYN_SENT     = 4'd1;
  localparam logic [StateW-1:0] ST_SYN_RECEIVED = 4'd2;
  localparam logic [StateW-1:0] ST_EST_TCP      = 4'd3;
  localparam logic [StateW-1:0] ST_EST_HTTP     = 4'd4;
  localparam logic [StateW-1:0] ST_EST_FTP_CON  = 4'd5;
  localparam logic [StateW-1:0] ST_EST_FTP_DATA = 4'd6;
  localparam logic [StateW-1:0] ST_FIN_WAIT_1   = 4'd7;
  localparam logic [StateW-1:0] ST_FIN_WAIT_2   = 4'd8;
  localparam logic [StateW-1:0] ST_CLOSE_WAIT   = 4'd9;
  localparam logic [StateW-1:0] ST_LAST_ACK     = 4'd10;
  localparam logic [StateW-1:0] ST_CLOSED       = 4'd11;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] REG_HTTP_PORT     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FTP_CTRL_PORT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FTP_DATA_PORT = 2'd2;

  // reset values of the port registers
  localparam logic [PortW-1:0] HTTP_PORT_RST     = 16'd80;
  localparam logic [PortW-1:0] FTP_CTRL_PORT_RST = 16'd21;
  localparam logic [PortW-1:0] FTP_DATA_PORT_RST = 16'd20;

  // verdict codes
  localparam logic VERDICT_DROP   = 1'b0;
  localparam logic VERDICT_ACCEPT = 1'b1;

  // action codes
  localparam logic ACT_FORWARD = 1'b0;
  localparam logic ACT_LOCAL   = 1'b1;

  typedef struct packed {
    logic [PortW-1:0] http_port;
    logic [PortW-1:0] ftp_control_port;
    logic [PortW-1:0] ftp_data_port;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic              syn_flag;
    logic              ack_flag;
    logic              fin_flag;
    logic [PortW-1:0]  dest_port;
    logic [PortW-1:0]  src_port;
    logic [StateW-1:0] own_state;
    logic [StateW-1:0] own_proxy_state;
    logic [StateW-1:0] twin_state;
    logic [StateW-1:0] twin_proxy_state;
  } item_t;

  typedef struct packed {
    logic              verdict;
    logic [StateW-1:0] new_own_state;
    logic [StateW-1:0] new_own_proxy_state;
    logic [StateW-1:0] new_twin_state;
    logic [StateW-1:0] new_twin_proxy_state;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/tcst_cfg_regs.sv -----
// tcst_cfg_regs: the three port match registers behind the write port
// depends on tcst_pkg for widths, indexes and reset values
`default_nettype none

module tcst_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [tcst_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [tcst_pkg::PortW-1:0]      cfg_data,
  output tcst_pkg::cfg_t                       cfg
);

  // register writes, unused index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.http_port        <= tcst_pkg::HTTP_PORT_RST;
      cfg.ftp_control_port <= tcst_pkg::FTP_CTRL_PORT_RST;
      cfg.ftp_data_port    <= tcst_pkg::FTP_DATA_PORT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tcst_pkg::REG_HTTP_PORT:     cfg.http_port        <= cfg_data;
        tcst_pkg::REG_FTP_CTRL_PORT: cfg.ftp_control_port <= cfg_data;
        tcst_pkg::REG_FTP_DATA_PORT: cfg.ftp_data_port    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcst_decide.sv -----
// tcst_decide: per-packet transition and verdict logic, purely combinational
// depends on tcst_pkg for state codes and the item and result structs
`default_nettype none

module tcst_decide (
  input  wire tcst_pkg::item_t item,
  input  wire tcst_pkg::cfg_t  cfg,
  output tcst_pkg::result_t    res
);

  logic [tcst_pkg::StateW-1:0] os, op, ts, tp;
  logic                        acc;
  logic                        http_hit, ftp_ctrl_hit, ftp_data_hit;
  logic                        op_est_proxy;

  assign http_hit     = (item.dest_port == cfg.http_port);
  assign ftp_ctrl_hit = (item.dest_port == cfg.ftp_control_port);
  assign ftp_data_hit = (item.src_port == cfg.ftp_data_port);
  assign op_est_proxy = (item.own_proxy_state == tcst_pkg::ST_EST_HTTP) ||
                        (item.own_proxy_state == tcst_pkg::ST_EST_FTP_CON);

  // transition rules, unchanged fields pass through
  always_comb begin
    os  = item.own_state;
    op  = item.own_proxy_state;
    ts  = item.twin_state;
    tp  = item.twin_proxy_state;
    acc = tcst_pkg::VERDICT_ACCEPT;
    if (item.action == tcst_pkg::ACT_LOCAL) begin
      // local packets move the proxy side, and the own state too when closing from last-ack
      if (item.fin_flag && op_est_proxy) begin
        op = tcst_pkg::ST_CLOSE_WAIT;
      end else if (item.fin_flag && item.own_proxy_state == tcst_pkg::ST_FIN_WAIT_1) begin
        op = tcst_pkg::ST_FIN_WAIT_2;
      end else if (item.own_proxy_state == tcst_pkg::ST_LAST_ACK) begin
        op = tcst_pkg::ST_CLOSED;
        os = tcst_pkg::ST_CLOSED;
      end
    end else begin
      case (item.own_state)
        tcst_pkg::ST_LISTEN: begin
          if (item.syn_flag && item.ack_flag) os = tcst_pkg::ST_SYN_RECEIVED;
          else acc = tcst_pkg::VERDICT_DROP;
        end
        tcst_pkg::ST_SYN_SENT: begin
          if (item.syn_flag || !item.ack_flag) begin
            acc = tcst_pkg::VERDICT_DROP;
          end else begin
            // later port matches override earlier ones
            os = tcst_pkg::ST_EST_TCP;
            ts = tcst_pkg::ST_EST_TCP;
            if (http_hit) begin
              os = tcst_pkg::ST_EST_HTTP;
              ts = tcst_pkg::ST_EST_HTTP;
              op = tcst_pkg::ST_EST_HTTP;
              tp = tcst_pkg::ST_EST_HTTP;
            end
            if (ftp_ctrl_hit) begin
              os = tcst_pkg::ST_EST_FTP_CON;
              ts = tcst_pkg::ST_EST_FTP_CON;
              op = tcst_pkg::ST_EST_FTP_CON;
              tp = tcst_pkg::ST_EST_FTP_CON;
            end
            if (ftp_data_hit) begin
              os = tcst_pkg::ST_EST_FTP_DATA;
              ts = tcst_pkg::ST_EST_FTP_DATA;
            end
          end
        end
        tcst_pkg::ST_SYN_RECEIVED, tcst_pkg::ST_CLOSED: begin
          acc = tcst_pkg::VERDICT_DROP;
        end
        tcst_pkg::ST_CLOSE_WAIT: begin
          if (item.fin_flag) begin
            os = tcst_pkg::ST_LAST_ACK;
            ts = tcst_pkg::ST_FIN_WAIT_2;
          end
        end
        tcst_pkg::ST_FIN_WAIT_1: ;
        tcst_pkg::ST_FIN_WAIT_2: begin
          os = tcst_pkg::ST_CLOSED;
          ts = tcst_pkg::ST_CLOSED;
        end
        tcst_pkg::ST_EST_TCP, tcst_pkg::ST_EST_FTP_DATA: begin
          if (item.fin_flag) begin
            os = tcst_pkg::ST_FIN_WAIT_1;
            ts = tcst_pkg::ST_CLOSE_WAIT;
          end
        end
        default: begin
          // proxy tracking, also taken by unused own state codes
          if (item.fin_flag) begin
            if (op_est_proxy) op = tcst_pkg::ST_FIN_WAIT_1;
            else if (item.own_proxy_state == tcst_pkg::ST_CLOSE_WAIT)
              op = tcst_pkg::ST_LAST_ACK;
          end else if (item.own_proxy_state == tcst_pkg::ST_FIN_WAIT_2) begin
            op = tcst_pkg::ST_CLOSED;
            os = tcst_pkg::ST_CLOSED;
          end
        end
      endcase
    end
  end

  assign res.verdict              = acc;
  assign res.new_own_state        = os;
  assign res.new_own_proxy_state  = op;
  assign res.new_twin_state       = ts;
  assign res.new_twin_proxy_state = tp;

endmodule

`default_nettype wire

// ----- rtl/tcp_connection_state_tracker.sv -----
// tcp_connection_state_tracker: input register, decision logic and result register lie
// in that order between start and done; one packet accepted every cycle,
// busy never rises and done is a one-cycle strobe the receiver cannot stall.
// synchronous reset clears the stage valid flags and loads the port
// registers with 80, 21 and 20; depends on tcst_pkg, tcst_cfg_regs, tcst_decide
`default_nettype none

module tcp_connection_state_tracker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tcst_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [tcst_pkg::PortW-1:0]       cfg_data,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic                             action,
  input  wire logic                             syn_flag,
  input  wire logic                             ack_flag,
  input  wire logic                             fin_flag,
  input  wire logic [tcst_pkg::PortW-1:0]       dest_port,
  input  wire logic [tcst_pkg::PortW-1:0]       src_port,
  input  wire logic [tcst_pkg::StateW-1:0]      own_state,
  input  wire logic [tcst_pkg::StateW-1:0]      own_proxy_state,
  input  wire logic [tcst_pkg::StateW-1:0]      twin_state,
  input  wire logic [tcst_pkg::StateW-1:0]      twin_proxy_state,
  output      logic                             done,
  output      logic                             verdict,
  output      logic [tcst_pkg::StateW-1:0]      new_own_state,
  output      logic [tcst_pkg::StateW-1:0]      new_own_proxy_state,
  output      logic [tcst_pkg::StateW-1:0]      new_twin_state,
  output      logic [tcst_pkg::StateW-1:0]      new_twin_proxy_state
);

  tcst_pkg::cfg_t    cfg;
  tcst_pkg::item_t   item_q;
  tcst_pkg::result_t res_d;
  tcst_pkg::result_t res_q;
  logic              item_valid;
  logic              in_xfer;

  // every cycle can take a packet
  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  tcst_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) item_valid <= 1'b0;
    else     item_valid <= in_xfer;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_q.action           <= action;
      item_q.syn_flag         <= syn_flag;
      item_q.ack_flag         <= ack_flag;
      item_q.fin_flag         <= fin_flag;
      item_q.dest_port        <= dest_port;
      item_q.src_port         <= src_port;
      item_q.own_state        <= own_state;
      item_q.own_proxy_state  <= own_proxy_state;
      item_q.twin_state       <= twin_state;
      item_q.twin_proxy_state <= twin_proxy_state;
    end
  end

  tcst_decide u_decide (
    .item (item_q),
    .cfg  (cfg),
    .res  (res_d)
  );

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (item_valid) res_q <= res_d;
  end

  assign verdict              = res_q.verdict;
  assign new_own_state        = res_q.new_own_state;
  assign new_own_proxy_state  = res_q.new_own_proxy_state;
  assign new_twin_state       = res_q.new_twin_state;
  assign new_twin_proxy_state = res_q.new_twin_proxy_state;

  // each accepted packet gives exactly one result after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> ##1 done)
    else $error("result strobe missing two cycles after start");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(item_valid))
    else $error("result strobe without a packet in flight");

  // local packets are always accepted and leave the twin row alone
  a_local_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_q.action == tcst_pkg::ACT_LOCAL |=>
      verdict == tcst_pkg::VERDICT_ACCEPT &&
      new_twin_state == $past(item_q.twin_state) &&
      new_twin_proxy_state == $past(item_q.twin_proxy_state))
    else $error("local packet dropped or twin state changed");

  // a dropped packet changes no state
  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    item_valid && res_d.verdict == tcst_pkg::VERDICT_DROP |->
      res_d.new_own_state == item_q.own_state &&
      res_d.new_twin_state == item_q.twin_state &&
      res_d.new_own_proxy_state == item_q.own_proxy_state)
    else $error("dropped packet changed a state");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for tcp_connection_state_tracker, a directed
// pass then random packets over several port settings; depends on tcst_pkg

module testbench;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PKTS_PER_SET = 212;

  // index past the last port register, must be ignored by the block
  localparam logic [tcst_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         cfg_we = 1'b0;
  logic [tcst_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [tcst_pkg::PortW-1:0]   cfg_data = '0;

  logic                        start = 1'b0;
  logic                        busy;
  logic                        action = 1'b0;
  logic                        syn_flag = 1'b0;
  logic                        ack_flag = 1'b0;
  logic                        fin_flag = 1'b0;
  logic [tcst_pkg::PortW-1:0]  dest_port = '0;
  logic [tcst_pkg::PortW-1:0]  src_port = '0;
  logic [tcst_pkg::StateW-1:0] own_state = '0;
  logic [tcst_pkg::StateW-1:0] own_proxy_state = '0;
  logic [tcst_pkg::StateW-1:0] twin_state = '0;
  logic [tcst_pkg::StateW-1:0] twin_proxy_state = '0;
  logic                        done;
  logic                        verdict;
  logic [tcst_pkg::StateW-1:0] new_own_state;
  logic [tcst_pkg::StateW-1:0] new_own_proxy_state;
  logic [tcst_pkg::StateW-1:0] new_twin_state;
  logic [tcst_pkg::StateW-1:0] new_twin_proxy_state;

  tcst_pkg::item_t   pending_pkts[$];
  tcst_pkg::result_t expected_results[$];
  tcst_pkg::item_t   drv_pkt = '0;
  tcst_pkg::cfg_t    port_cfg;
  int                idle_pct = 31;
  int                mismatch_cnt = 0;
  int                quiet_cycles = 0;

  // connection walk carried from one packet to the next
  tcst_pkg::item_t walk_pkt = '0;
  int              walk_len = 0;

  tcp_connection_state_tracker DUT (.*);

  always #1 clk = ~clk;

  // expected verdict and new states of one packet
  function automatic tcst_pkg::result_t predict_conn_step(tcst_pkg::item_t pkt,
                                                          tcst_pkg::cfg_t c);
    tcst_pkg::result_t           r;
    logic [tcst_pkg::StateW-1:0] os, op, ts, tp;
    logic                        accept;
    os = pkt.own_state;
    op = pkt.own_proxy_state;
    ts = pkt.twin_state;
    tp = pkt.twin_proxy_state;
    accept = tcst_pkg::VERDICT_ACCEPT;
    if (pkt.action == tcst_pkg::ACT_LOCAL) begin
      // local packets move the proxy side, and the own state too when closing from last-ack
      if (pkt.fin_flag && (op == tcst_pkg::ST_EST_HTTP ||
                           op == tcst_pkg::ST_EST_FTP_CON)) begin
        op = tcst_pkg::ST_CLOSE_WAIT;
      end else if (pkt.fin_flag && op == tcst_pkg::ST_FIN_WAIT_1) begin
        op = tcst_pkg::ST_FIN_WAIT_2;
      end else if (op == tcst_pkg::ST_LAST_ACK) begin
        op = tcst_pkg::ST_CLOSED;
        os = tcst_pkg::ST_CLOSED;
      end
    end else begin
      case (os)
        tcst_pkg::ST_LISTEN: begin
          if (pkt.syn_flag && pkt.ack_flag) os = tcst_pkg::ST_SYN_RECEIVED;
          else accept = tcst_pkg::VERDICT_DROP;
        end
        tcst_pkg::ST_SYN_SENT: begin
          if (pkt.syn_flag && pkt.ack_flag) begin
            accept = tcst_pkg::VERDICT_DROP;
          end else if (pkt.ack_flag) begin
            // later port matches override earlier ones
            os = tcst_pkg::ST_EST_TCP;
            ts = tcst_pkg::ST_EST_TCP;
            if (pkt.dest_port == c.http_port) begin
              os = tcst_pkg::ST_EST_HTTP;
              ts = tcst_pkg::ST_EST_HTTP;
              op = tcst_pkg::ST_EST_HTTP;
              tp = tcst_pkg::ST_EST_HTTP;
            end
            if (pkt.dest_port == c.ftp_control_port) begin
              os = tcst_pkg::ST_EST_FTP_CON;
              ts = tcst_pkg::ST_EST_FTP_CON;
              op = tcst_pkg::ST_EST_FTP_CON;
              tp = tcst_pkg::ST_EST_FTP_CON;
            end
            if (pkt.src_port == c.ftp_data_port) begin
              os = tcst_pkg::ST_EST_FTP_DATA;
              ts = tcst_pkg::ST_EST_FTP_DATA;
            end
          end else begin
            accept = tcst_pkg::VERDICT_DROP;
          end
        end
        tcst_pkg::ST_SYN_RECEIVED, tcst_pkg::ST_CLOSED: begin
          accept = tcst_pkg::VERDICT_DROP;
        end
        tcst_pkg::ST_CLOSE_WAIT: begin
          if (pkt.fin_flag) begin
            os = tcst_pkg::ST_LAST_ACK;
            ts = tcst_pkg::ST_FIN_WAIT_2;
          end
        end
        tcst_pkg::ST_FIN_WAIT_1: begin
          // accepted, states kept
        end
        tcst_pkg::ST_FIN_WAIT_2: begin
          os = tcst_pkg::ST_CLOSED;
          ts = tcst_pkg::ST_CLOSED;
        end
        tcst_pkg::ST_EST_TCP, tcst_pkg::ST_EST_FTP_DATA: begin
          if (pkt.fin_flag) begin
            os = tcst_pkg::ST_FIN_WAIT_1;
            ts = tcst_pkg::ST_CLOSE_WAIT;
          end
        end
        default: begin
          // proxied connections and unused codes
          if (pkt.fin_flag) begin
            if (op == tcst_pkg::ST_EST_HTTP || op == tcst_pkg::ST_EST_FTP_CON)
              op = tcst_pkg::ST_FIN_WAIT_1;
            else if (op == tcst_pkg::ST_CLOSE_WAIT)
              op = tcst_pkg::ST_LAST_ACK;
          end else if (op == tcst_pkg::ST_FIN_WAIT_2) begin
            op = tcst_pkg::ST_CLOSED;
            os = tcst_pkg::ST_CLOSED;
          end
        end
      endcase
    end
    r.verdict = accept;
    r.new_own_state = os;
    r.new_own_proxy_state = op;
    r.new_twin_state = ts;
    r.new_twin_proxy_state = tp;
    return r;
  endfunction

  function automatic tcst_pkg::item_t make_pkt(logic act, logic syn, logic ack, logic fin,
      logic [tcst_pkg::PortW-1:0] dp, logic [tcst_pkg::PortW-1:0] sp,
      logic [tcst_pkg::StateW-1:0] os, logic [tcst_pkg::StateW-1:0] op,
      logic [tcst_pkg::StateW-1:0] ts, logic [tcst_pkg::StateW-1:0] tp);
    tcst_pkg::item_t p;
    p.action = act;
    p.syn_flag = syn;
    p.ack_flag = ack;
    p.fin_flag = fin;
    p.dest_port = dp;
    p.src_port = sp;
    p.own_state = os;
    p.own_proxy_state = op;
    p.twin_state = ts;
    p.twin_proxy_state = tp;
    return p;
  endfunction

  // ports that hit the configured values often
  function automatic logic [tcst_pkg::PortW-1:0] pick_port();
    case ($urandom_range(5))
      0: return port_cfg.http_port;
      1: return port_cfg.ftp_control_port;
      2: return port_cfg.ftp_data_port;
      3: return '0;
      4: return '1;
      default: return tcst_pkg::PortW'($urandom);
    endcase
  endfunction

  // mostly valid codes, sometimes the unused ones
  function automatic logic [tcst_pkg::StateW-1:0] pick_state();
    if ($urandom_range(9) == 0) return tcst_pkg::StateW'($urandom_range(15, 12));
    return tcst_pkg::StateW'($urandom_range(11));
  endfunction

  function automatic tcst_pkg::item_t random_pkt();
    tcst_pkg::item_t p;
    p.action = 1'($urandom_range(1));
    p.syn_flag = 1'($urandom_range(1));
    p.ack_flag = 1'($urandom_range(1));
    p.fin_flag = 1'($urandom_range(1));
    p.dest_port = pick_port();
    p.src_port = pick_port();
    p.own_state = pick_state();
    p.own_proxy_state = pick_state();
    p.twin_state = pick_state();
    p.twin_proxy_state = pick_state();
    return p;
  endfunction

  // mix of connection walks from a handshake start and loose packets
  task automatic queue_random_pkts(input int n);
    tcst_pkg::item_t   p;
    tcst_pkg::result_t r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 6) begin
        if (walk_len == 0 || walk_len > 12 || walk_pkt.own_state == tcst_pkg::ST_CLOSED ||
            walk_pkt.own_state == tcst_pkg::ST_SYN_RECEIVED) begin
          walk_pkt.own_state = ($urandom_range(3) == 0) ? tcst_pkg::ST_LISTEN :
                                                          tcst_pkg::ST_SYN_SENT;
          walk_pkt.twin_state = tcst_pkg::ST_LISTEN;
          walk_pkt.own_proxy_state = tcst_pkg::ST_LISTEN;
          walk_pkt.twin_proxy_state = tcst_pkg::ST_LISTEN;
          walk_len = 0;
        end
        p = walk_pkt;
        p.action = ($urandom_range(4) == 0) ? tcst_pkg::ACT_LOCAL : tcst_pkg::ACT_FORWARD;
        p.syn_flag = 1'($urandom_range(1));
        p.ack_flag = 1'($urandom_range(1));
        p.fin_flag = 1'($urandom_range(1));
        p.dest_port = pick_port();
        p.src_port = pick_port();
        r = predict_conn_step(p, port_cfg);
        // next packet comes from the same side or from the twin
        if ($urandom_range(1) == 0) begin
          walk_pkt.own_state = r.new_own_state;
          walk_pkt.own_proxy_state = r.new_own_proxy_state;
          walk_pkt.twin_state = r.new_twin_state;
          walk_pkt.twin_proxy_state = r.new_twin_proxy_state;
        end else begin
          walk_pkt.own_state = r.new_twin_state;
          walk_pkt.own_proxy_state = r.new_twin_proxy_state;
          walk_pkt.twin_state = r.new_own_state;
          walk_pkt.twin_proxy_state = r.new_own_proxy_state;
        end
        walk_len++;
      end else begin
        p = random_pkt();
      end
      pending_pkts.push_back(p);
    end
  endtask

  // waits at falling edges until every packet is out and checked
  task automatic wait_drained();
    while (pending_pkts.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // loads the three port registers plus a write to the spare index
  task automatic write_port_regs(input logic [tcst_pkg::PortW-1:0] http,
                                 input logic [tcst_pkg::PortW-1:0] ftp_ctrl,
                                 input logic [tcst_pkg::PortW-1:0] ftp_data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= tcst_pkg::REG_HTTP_PORT;
    cfg_data <= http;
    port_cfg.http_port = http;
    @(posedge clk);
    cfg_index <= tcst_pkg::REG_FTP_CTRL_PORT;
    cfg_data <= ftp_ctrl;
    port_cfg.ftp_control_port = ftp_ctrl;
    @(posedge clk);
    cfg_index <= tcst_pkg::REG_FTP_DATA_PORT;
    cfg_data <= ftp_data;
    port_cfg.ftp_data_port = ftp_data;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= tcst_pkg::PortW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // packet driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // a transfer takes place when start meets a low busy
      if (start && !busy)
        expected_results.push_back(predict_conn_step(drv_pkt, port_cfg));
      if (!(start && busy)) begin
        if (pending_pkts.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drv_pkt = pending_pkts.pop_front();
          start <= 1'b1;
          action <= drv_pkt.action;
          syn_flag <= drv_pkt.syn_flag;
          ack_flag <= drv_pkt.ack_flag;
          fin_flag <= drv_pkt.fin_flag;
          dest_port <= drv_pkt.dest_port;
          src_port <= drv_pkt.src_port;
          own_state <= drv_pkt.own_state;
          own_proxy_state <= drv_pkt.own_proxy_state;
          twin_state <= drv_pkt.twin_state;
          twin_proxy_state <= drv_pkt.twin_proxy_state;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_cnt++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    tcst_pkg::result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no packet outstanding");
        mismatch_cnt++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("verdict", int'(exp_r.verdict), int'(verdict));
        check_field("new_own_state", int'(exp_r.new_own_state), int'(new_own_state));
        check_field("new_own_proxy_state", int'(exp_r.new_own_proxy_state),
                    int'(new_own_proxy_state));
        check_field("new_twin_state", int'(exp_r.new_twin_state), int'(new_twin_state));
        check_field("new_twin_proxy_state", int'(exp_r.new_twin_proxy_state),
                    int'(new_twin_proxy_state));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    port_cfg.http_port = tcst_pkg::HTTP_PORT_RST;
    port_cfg.ftp_control_port = tcst_pkg::FTP_CTRL_PORT_RST;
    port_cfg.ftp_data_port = tcst_pkg::FTP_DATA_PORT_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed packets under the reset port values
    idle_pct = 31;
    // handshake from listen
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b1, 1'b1, 1'b0, 16'd1000,
                                    16'd2000, tcst_pkg::ST_LISTEN, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_SYN_SENT, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b1, 1'b0, 1'b0, 16'd1000,
                                    16'd2000, tcst_pkg::ST_LISTEN, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_SYN_SENT, tcst_pkg::ST_LISTEN));
    // syn-sent: drop on syn+ack, plain, http, ftp control, ftp data, no ack
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b1, 1'b1, 1'b0, 16'd1000,
                                    16'd2000, tcst_pkg::ST_SYN_SENT, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_LISTEN, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b0, 16'd1234,
                                    16'd5555, tcst_pkg::ST_SYN_SENT, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_SYN_RECEIVED, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b0, 16'd80,
                                    16'd5555, tcst_pkg::ST_SYN_SENT, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_SYN_RECEIVED, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b0, 16'd21,
                                    16'd5555, tcst_pkg::ST_SYN_SENT, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_SYN_RECEIVED, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b0, 16'd21,
                                    16'd20, tcst_pkg::ST_SYN_SENT, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_SYN_RECEIVED, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b1, 1'b0, 1'b1, 16'd80,
                                    16'd20, tcst_pkg::ST_SYN_SENT, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_LISTEN, tcst_pkg::ST_LISTEN));
    // dead states drop
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b1, 1'b1, 1'b1, 16'd80,
                                    16'd20, tcst_pkg::ST_SYN_RECEIVED,
                                    tcst_pkg::ST_EST_HTTP, tcst_pkg::ST_SYN_SENT,
                                    tcst_pkg::ST_EST_HTTP));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b1, 16'd21,
                                    16'd20, tcst_pkg::ST_CLOSED, tcst_pkg::ST_LAST_ACK,
                                    tcst_pkg::ST_CLOSED, tcst_pkg::ST_CLOSED));
    // close sequence on plain connections
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b1, 16'd1,
                                    16'd2, tcst_pkg::ST_EST_TCP, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_EST_TCP, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b0, 16'd1,
                                    16'd2, tcst_pkg::ST_EST_FTP_DATA, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_EST_FTP_DATA, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b1, 16'd1,
                                    16'd2, tcst_pkg::ST_CLOSE_WAIT, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_FIN_WAIT_1, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b1, 16'd1,
                                    16'd2, tcst_pkg::ST_FIN_WAIT_1, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_CLOSE_WAIT, tcst_pkg::ST_LISTEN));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b0, 16'd1,
                                    16'd2, tcst_pkg::ST_FIN_WAIT_2, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_LAST_ACK, tcst_pkg::ST_LISTEN));
    // proxy tracking on forwarded packets
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b1, 16'd80,
                                    16'd2, tcst_pkg::ST_EST_HTTP, tcst_pkg::ST_EST_HTTP,
                                    tcst_pkg::ST_EST_HTTP, tcst_pkg::ST_EST_HTTP));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b1, 16'd80,
                                    16'd2, tcst_pkg::ST_LAST_ACK, tcst_pkg::ST_CLOSE_WAIT,
                                    tcst_pkg::ST_FIN_WAIT_2, tcst_pkg::ST_EST_HTTP));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b1, 1'b0, 16'd21,
                                    16'd2, tcst_pkg::ST_EST_FTP_CON,
                                    tcst_pkg::ST_FIN_WAIT_2, tcst_pkg::ST_EST_FTP_CON,
                                    tcst_pkg::ST_LAST_ACK));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b0, 1'b1, 16'd21,
                                    16'd2, 4'd15, tcst_pkg::ST_EST_FTP_CON, 4'd12,
                                    4'd13));
    // locally generated packets
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_LOCAL, 1'b0, 1'b1, 1'b1, 16'd80,
                                    16'd2, tcst_pkg::ST_EST_HTTP, tcst_pkg::ST_EST_HTTP,
                                    tcst_pkg::ST_EST_HTTP, tcst_pkg::ST_EST_HTTP));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_LOCAL, 1'b0, 1'b1, 1'b1, 16'd80,
                                    16'd2, tcst_pkg::ST_EST_HTTP, tcst_pkg::ST_FIN_WAIT_1,
                                    tcst_pkg::ST_EST_HTTP, tcst_pkg::ST_EST_HTTP));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_LOCAL, 1'b1, 1'b1, 1'b0, 16'd80,
                                    16'd2, tcst_pkg::ST_LAST_ACK, tcst_pkg::ST_LAST_ACK,
                                    tcst_pkg::ST_FIN_WAIT_2, tcst_pkg::ST_EST_HTTP));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_LOCAL, 1'b1, 1'b0, 1'b1, 16'hFFFF,
                                    16'hFFFF, 4'd15, 4'd15, 4'd15, 4'd15));
    // field extremes
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b1, 1'b1, 1'b1, 16'hFFFF,
                                    16'hFFFF, 4'd15, 4'd15, 4'd15, 4'd15));
    pending_pkts.push_back(make_pkt(tcst_pkg::ACT_FORWARD, 1'b0, 1'b0, 1'b0, 16'd0,
                                    16'd0, tcst_pkg::ST_LISTEN, tcst_pkg::ST_LISTEN,
                                    tcst_pkg::ST_LISTEN, tcst_pkg::ST_LISTEN));
    wait_drained();

    // random packets across port settings, idling rises for the middle two and stops for the last two
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: write_port_regs(tcst_pkg::HTTP_PORT_RST, tcst_pkg::FTP_CTRL_PORT_RST,
                           tcst_pkg::FTP_DATA_PORT_RST);
        1: write_port_regs('0, '0, '0);
        2: write_port_regs('1, '1, '1);
        3: write_port_regs(tcst_pkg::PortW'($urandom), tcst_pkg::PortW'($urandom),
                           tcst_pkg::PortW'($urandom));
        4: write_port_regs(16'd443, 16'd443, 16'd8080);
        default: write_port_regs(tcst_pkg::PortW'($urandom), tcst_pkg::PortW'($urandom),
                                 tcst_pkg::PortW'($urandom));
      endcase
      idle_pct = (s < 2) ? 31 : ((s < 4) ? 67 : 0);
      queue_random_pkts(PKTS_PER_SET);
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
